// File: sv/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the timer expiry queue.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int DL_W   = 48;
	localparam int SEQ_W  = 32;
	localparam int ID_W   = 4;
	localparam int IVL_W  = 32;
	localparam int CNT_W  = 5;

	localparam logic [DL_W-1:0]  DL_MAX   = {DL_W{1'b1}};
	localparam logic [CNT_W-1:0] FIRE_MAX = CNT_W'(16);

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_DEL = 2'd1,
		MODE_ADV = 2'd2,
		MODE_QRY = 2'd3
	} mode_t;

	// one memory word per slot
	typedef struct packed {
		logic [DL_W-1:0]  dl;
		logic [SEQ_W-1:0] seq;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/teq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module teq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/teq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_scan
// Walks every slot of the memory and keeps the earliest armed one.
// ----------------------------------------------------------------------------
module teq_scan #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [TIMER_SLOTS-1:0]           armed,
	output logic                             rd_en,
	output logic [$clog2(TIMER_SLOTS)-1:0]   rd_addr,
	input  teq_pkg::entry_t                  rd_data,
	output logic                             done,
	output logic                             best_valid,
	output logic [$clog2(TIMER_SLOTS)-1:0]   best_idx,
	output logic [teq_pkg::DL_W-1:0]         best_dl
);
	import teq_pkg::*;

	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TIMER_SLOTS - 1);

	logic              run_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              best_valid_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [DL_W-1:0]   best_dl_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic              better;

	assign rd_en   = run_q;
	assign rd_addr = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= run_q;
			idx_s1 <= cnt_q;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// strict compare keeps the lower slot on a full tie
	always_comb begin
		better = armed[idx_s1] && (!best_valid_q || (rd_data.dl < best_dl_q) ||
			((rd_data.dl == best_dl_q) && (rd_data.seq < best_seq_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (start) begin
			best_valid_q <= 1'b0;
		end else if (vld_s1 && better) begin
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && better) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= rd_data.dl;
			best_seq_q <= rd_data.seq;
		end
	end

	assign done       = vld_s1 && (idx_s1 == LAST);
	assign best_valid = best_valid_q;
	assign best_idx   = best_idx_q;
	assign best_dl    = best_dl_q;

endmodule

// File: sv/timer_expiry_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_expiry_queue_top
// One-shot timer queue indexed by slot, ordered by deadline then sequence.
// Add, delete, query and an advance that fires nothing give their single beat
//   after one full scan of the memory.
// An advance firing k slots runs k + 1 scans; each result needs one full serial
//   scan through the memory read port.
// Reset: armed bits, time and sequence counter clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module timer_expiry_queue_top #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic [teq_pkg::ID_W-1:0]    timer_id,
	input  logic [teq_pkg::IVL_W-1:0]   interval,
	input  logic [teq_pkg::DL_W-1:0]    now_ms,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic                        fired_valid,
	output logic [teq_pkg::ID_W-1:0]    fired_id,
	output logic                        last,
	output logic                        next_valid,
	output logic [teq_pkg::ID_W-1:0]    next_id,
	output logic [teq_pkg::DL_W-1:0]    next_deadline
);
	import teq_pkg::*;

	localparam int SLOT_W = $clog2(TIMER_SLOTS);

	// control sequencer, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// queue state
	logic [DL_W-1:0]        cur_time_q;
	logic [SEQ_W-1:0]       seq_q;
	logic [TIMER_SLOTS-1:0] armed_q;

	// item being worked on
	mode_t             mode_q;
	logic              status_q;
	logic              fire_pend_q;
	logic [SLOT_W-1:0] pend_id_q;
	logic [CNT_W-1:0]  fire_cnt_q;

	// output register
	logic              out_valid_q;
	logic              res_status_q;
	logic              res_fired_q;
	logic [ID_W-1:0]   res_fid_q;
	logic              res_last_q;
	logic              res_nvalid_q;
	logic [ID_W-1:0]   res_nid_q;
	logic [DL_W-1:0]   res_ndl_q;

	// memory and scanner hookup
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_entry;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_word;
	logic              scan_start;
	logic              scan_done;
	logic              best_valid;
	logic [SLOT_W-1:0] best_idx;
	logic [DL_W-1:0]   best_dl;

	// datapath
	logic              accept;
	mode_t             in_mode;
	logic              in_range;
	logic [SLOT_W-1:0] in_slot;
	logic [DL_W:0]     dl_sum;
	logic              fire_next;
	logic              need_out;
	logic              out_free;
	logic              emit_go;
	logic              emit_out;
	logic              rescan;

	assign in_mode  = mode_t'(mode);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(timer_id) < 32'(TIMER_SLOTS));
	assign in_slot  = SLOT_W'(timer_id);

	// deadline saturates at the top of the 48-bit range
	assign dl_sum       = {1'b0, cur_time_q} + (DL_W + 1)'(interval);
	assign wr_entry.dl  = dl_sum[DL_W] ? DL_MAX : dl_sum[DL_W-1:0];
	assign wr_entry.seq = seq_q;
	assign wr_en        = accept && (in_mode == MODE_ADD) && in_range;
	assign wr_addr      = in_slot;

	teq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TIMER_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	teq_scan #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.armed      (armed_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_word),
		.done       (scan_done),
		.best_valid (best_valid),
		.best_idx   (best_idx),
		.best_dl    (best_dl)
	);

	// after a scan: does the earliest slot expire now, within the per-advance cap
	always_comb begin
		fire_next = (mode_q == MODE_ADV) && best_valid && (best_dl <= cur_time_q) &&
			(fire_cnt_q < FIRE_MAX);
		// a pending fire is reported once the rescan after its disarm is done
		need_out  = fire_pend_q || !fire_next;
		out_free  = !out_valid_q || !out_stall;
		emit_go   = (state_q == ST_EMIT) && (!need_out || out_free);
		emit_out  = emit_go && need_out;
		rescan    = emit_go && fire_next;
		scan_start = accept || rescan;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = fire_next ? ST_SCAN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_time_q  <= '0;
			seq_q       <= '0;
			armed_q     <= '0;
			mode_q      <= MODE_QRY;
			status_q    <= 1'b0;
			fire_pend_q <= 1'b0;
			pend_id_q   <= '0;
			fire_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q      <= in_mode;
				fire_pend_q <= 1'b0;
				fire_cnt_q  <= '0;
				status_q    <= 1'b0;
				case (in_mode)
					MODE_ADD: begin
						if (in_range) begin
							armed_q[in_slot] <= 1'b1;
							seq_q            <= seq_q + 1'b1;
						end
					end
					MODE_DEL: begin
						if (in_range && armed_q[in_slot]) begin
							armed_q[in_slot] <= 1'b0;
						end else begin
							status_q <= 1'b1;
						end
					end
					MODE_ADV: begin
						cur_time_q <= now_ms;
					end
					default: begin
					end
				endcase
			end else if (rescan) begin
				// disarm the expiring slot and look again
				armed_q[best_idx] <= 1'b0;
				pend_id_q         <= best_idx;
				fire_pend_q       <= 1'b1;
				fire_cnt_q        <= fire_cnt_q + 1'b1;
			end else if (emit_go) begin
				fire_pend_q <= 1'b0;
			end
		end
	end

	// output register, one beat held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_out) begin
			res_status_q <= fire_pend_q ? 1'b0 : status_q;
			res_fired_q  <= fire_pend_q;
			res_fid_q    <= fire_pend_q ? ID_W'(pend_id_q) : '0;
			res_last_q   <= !fire_next;
			res_nvalid_q <= best_valid;
			res_nid_q    <= best_valid ? ID_W'(best_idx) : '0;
			res_ndl_q    <= best_valid ? best_dl : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_status_q;
	assign fired_valid   = res_fired_q;
	assign fired_id      = res_fid_q;
	assign last          = res_last_q;
	assign next_valid    = res_nvalid_q;
	assign next_id       = res_nid_q;
	assign next_deadline = res_ndl_q;

endmodule
